// ===== rtl/rdfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rdfd_pkg: shared types and constants for the delimited record field decoder
// Register indexes, configuration bundle and result beat layout.
// ----------------------------------------------------------------------------
package rdfd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_FIELD_DELIMITER  = 3'd0;
    localparam logic [2:0] REG_ESCAPE_ENABLE    = 3'd1;
    localparam logic [2:0] REG_ESCAPE_BYTE      = 3'd2;
    localparam logic [2:0] REG_NULL_LITERAL     = 3'd3;
    localparam logic [2:0] REG_NULL_LENGTH      = 3'd4;
    localparam logic [2:0] REG_PROJECTION_MASK  = 3'd5;
    localparam logic [2:0] REG_TAKE_REST_ENABLE = 3'd6;
    localparam logic [2:0] REG_FILE_FIELD_COUNT = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Result kinds
    localparam logic KIND_DATA      = 1'b0;
    localparam logic KIND_FIELD_END = 1'b1;

    // Result queue depth; an item pushes up to two beats
    localparam int RES_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  field_delimiter;
        logic        escape_enable;
        logic [7:0]  escape_byte;
        logic [63:0] null_literal;
        logic [3:0]  null_length;
        logic [63:0] projection_mask;
        logic        take_rest_enable;
        logic [6:0]  file_field_count;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [5:0] source_field;
        logic       field_is_null;
        logic       last;
    } result_t;

endpackage

// ===== rtl/rdfd_decode.sv =====
// ----------------------------------------------------------------------------
// rdfd_decode: per-byte field split, escape and null-match logic
// Holds the record state and turns one item into up to two result beats.
// ----------------------------------------------------------------------------
module rdfd_decode #(
    parameter int MAX_FIELDS = 64,
    parameter int NULL_MAX   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rdfd_pkg::cfg_t     cfg,
    input  logic               item_go,
    input  logic [7:0]         data_byte,
    input  logic               has_byte,
    input  logic               record_end,
    output logic [1:0]         res_vld,
    output rdfd_pkg::result_t  res0,
    output rdfd_pkg::result_t  res1
);

    localparam int FC_W = $clog2(MAX_FIELDS + 1);
    localparam int RL_W = $clog2(NULL_MAX + 2);

    logic [FC_W-1:0] fc_reg, fc_next;
    logic            ep_reg, ep_next;
    logic [RL_W-1:0] rl_reg, rl_next;
    logic            nm_reg, nm_next;

    logic            is_esc, is_delim, take, data_v, fend_v;
    logic [7:0]      data_b;
    logic [2:0]      lit_idx;
    logic [7:0]      lit;
    logic            nm_t, nm_a, nm_b;
    logic [RL_W-1:0] rl_t, rl_a, rl_b;
    logic [FC_W-1:0] fc_inc, fc_a;
    logic            proj0, proj1;

    function automatic logic projected(input logic [FC_W-1:0] fc, input logic [63:0] mask);
        logic ok;
        ok = (fc < FC_W'(MAX_FIELDS)) && mask[6'(fc)];
        return ok;
    endfunction

    always_comb
    begin
        is_esc   = cfg.escape_enable && (data_byte == cfg.escape_byte);
        is_delim = (data_byte == cfg.field_delimiter) &&
                   !(cfg.take_rest_enable && (7'(fc_reg) + 7'd1 == cfg.file_field_count));

        take    = 1'b0;
        data_v  = 1'b0;
        fend_v  = 1'b0;
        data_b  = data_byte;
        ep_next = ep_reg;

        if (has_byte)
        begin
            if (ep_reg)
            begin
                ep_next = 1'b0;
                take    = 1'b1;
                data_v  = 1'b1;
            end
            else if (is_esc)
            begin
                take = 1'b1;
                if (record_end)
                    data_v = 1'b1;
                else
                    ep_next = 1'b1;
            end
            else if (is_delim)
            begin
                fend_v  = 1'b1;
                ep_next = 1'b0;
            end
            else
            begin
                take   = 1'b1;
                data_v = 1'b1;
            end
        end
        else if (record_end && ep_reg)
        begin
            data_v = 1'b1;
            data_b = cfg.escape_byte;
        end

        // running null-literal compare on the raw byte
        lit_idx = 3'(rl_reg);
        lit     = cfg.null_literal[{lit_idx, 3'b000} +: 8];
        nm_t    = nm_reg && (4'(rl_reg) < cfg.null_length) &&
                  (rl_reg < RL_W'(NULL_MAX)) && (lit == data_byte);
        rl_t    = (rl_reg < RL_W'(NULL_MAX + 1)) ? rl_reg + RL_W'(1) : rl_reg;

        rl_a   = take ? rl_t : rl_reg;
        nm_a   = take ? nm_t : nm_reg;
        fc_inc = (fc_reg < FC_W'(MAX_FIELDS)) ? fc_reg + FC_W'(1) : fc_reg;
        fc_a   = fend_v ? fc_inc : fc_reg;
        rl_b   = fend_v ? '0 : rl_a;
        nm_b   = fend_v ? 1'b1 : nm_a;

        proj0 = projected(fc_reg, cfg.projection_mask);
        proj1 = projected(fc_a, cfg.projection_mask);

        res_vld[0] = (data_v || fend_v) && proj0;
        res_vld[1] = record_end && proj1;

        res0.kind          = fend_v ? rdfd_pkg::KIND_FIELD_END : rdfd_pkg::KIND_DATA;
        res0.out_byte      = fend_v ? 8'd0 : data_b;
        res0.source_field  = 6'(fc_reg);
        res0.field_is_null = fend_v && nm_a && (4'(rl_a) == cfg.null_length);
        res0.last          = record_end && !res_vld[1];

        res1.kind          = rdfd_pkg::KIND_FIELD_END;
        res1.out_byte      = 8'd0;
        res1.source_field  = 6'(fc_a);
        res1.field_is_null = nm_b && (4'(rl_b) == cfg.null_length);
        res1.last          = 1'b1;

        if (record_end)
        begin
            fc_next = '0;
            rl_next = '0;
            nm_next = 1'b1;
            ep_next = 1'b0;
        end
        else
        begin
            fc_next = fc_a;
            rl_next = rl_b;
            nm_next = nm_b;
        end

        // nothing happens when no item is presented
        if (!item_go)
            res_vld = 2'b00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= '0;
            ep_reg <= 1'b0;
            rl_reg <= '0;
            nm_reg <= 1'b1;
        end
        else if (item_go)
        begin
            fc_reg <= fc_next;
            ep_reg <= ep_next;
            rl_reg <= rl_next;
            nm_reg <= nm_next;
        end
    end

endmodule

// ===== rtl/rdfd_res_fifo.sv =====
// ----------------------------------------------------------------------------
// rdfd_res_fifo: result beat queue
// Takes up to two beats per cycle, hands out one beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module rdfd_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_vld,
    input  rdfd_pkg::result_t push0,
    input  rdfd_pkg::result_t push1,
    output logic              room2,
    output logic              out_valid,
    input  logic              out_stall,
    output rdfd_pkg::result_t head
);

    localparam int DEPTH = rdfd_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rdfd_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pop;
    logic [1:0]        n_push;
    rdfd_pkg::result_t first;

    assign out_valid = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];
    assign room2     = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && !out_stall;
    assign n_push    = 2'(push_vld[0]) + 2'(push_vld[1]);
    assign first     = push_vld[0] ? push0 : push1;

    always_comb
    begin
        wp_next  = wp_reg + PTR_W'(n_push);
        rp_next  = pop ? rp_reg + PTR_W'(1) : rp_reg;
        cnt_next = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wp_reg] <= first;
        if (n_push == 2'd2)
            mem_reg[wp_reg + PTR_W'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/delimited_record_field_decoder_core.sv =====
// ----------------------------------------------------------------------------
// delimited_record_field_decoder_core: beats pass the input register, then the result queue.
// One input beat per cycle while the queue has room; two-result items use two output beats.
// Async active-low reset: record state cleared, queue empty, registers at defaults.
// ----------------------------------------------------------------------------
module delimited_record_field_decoder_core #(
    parameter int MAX_FIELDS = 64,
    parameter int NULL_MAX   = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [rdfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            has_byte,
    input  logic                            record_end,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kind,
    output logic [7:0]                      out_byte,
    output logic [5:0]                      source_field,
    output logic                            field_is_null,
    output logic                            last
);

    // Configuration registers, reset to the documented defaults.
    rdfd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_delimiter  <= 8'd1;
            cfg_reg.escape_enable    <= 1'b0;
            cfg_reg.escape_byte      <= 8'd92;
            cfg_reg.null_literal     <= 64'd20060;   // backslash, 'N'
            cfg_reg.null_length      <= 4'd2;
            cfg_reg.projection_mask  <= '1;
            cfg_reg.take_rest_enable <= 1'b0;
            cfg_reg.file_field_count <= 7'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rdfd_pkg::REG_FIELD_DELIMITER:  cfg_reg.field_delimiter  <= cfg_wdata[7:0];
                rdfd_pkg::REG_ESCAPE_ENABLE:    cfg_reg.escape_enable    <= cfg_wdata[0];
                rdfd_pkg::REG_ESCAPE_BYTE:      cfg_reg.escape_byte      <= cfg_wdata[7:0];
                rdfd_pkg::REG_NULL_LITERAL:     cfg_reg.null_literal     <= cfg_wdata;
                rdfd_pkg::REG_NULL_LENGTH:      cfg_reg.null_length      <= cfg_wdata[3:0];
                rdfd_pkg::REG_PROJECTION_MASK:  cfg_reg.projection_mask  <= cfg_wdata;
                rdfd_pkg::REG_TAKE_REST_ENABLE: cfg_reg.take_rest_enable <= cfg_wdata[0];
                rdfd_pkg::REG_FILE_FIELD_COUNT: cfg_reg.file_field_count <= cfg_wdata[6:0];
                default:                        cfg_reg.field_delimiter  <= cfg_reg.field_delimiter;
            endcase
        end
    end

    // Input register. A held beat advances into the decoder once the result
    // queue has room for the two beats an item can produce; a new beat is loaded
    // in the same cycle, so the pipe runs at one item per clock while there is room.
    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       has_reg;
    logic       rend_reg;
    logic       room2;
    logic       adv;

    assign adv      = in_vld_reg && room2;
    assign in_stall = in_vld_reg && !room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            has_reg  <= has_byte;
            rend_reg <= record_end;
        end
    end

    // Decode stage: field split, escape, null match and projection.
    logic [1:0]        res_vld;
    rdfd_pkg::result_t res0;
    rdfd_pkg::result_t res1;

    rdfd_decode #(
        .MAX_FIELDS (MAX_FIELDS),
        .NULL_MAX   (NULL_MAX)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_go    (adv),
        .data_byte  (byte_reg),
        .has_byte   (has_reg),
        .record_end (rend_reg),
        .res_vld    (res_vld),
        .res0       (res0),
        .res1       (res1)
    );

    // Result queue decouples the two-beat bursts from the output channel.
    rdfd_pkg::result_t head;

    rdfd_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (res_vld),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind          = head.kind;
    assign out_byte      = head.out_byte;
    assign source_field  = head.source_field;
    assign field_is_null = head.field_is_null;
    assign last          = head.last;

endmodule
